### design/fan_triangle_assembly_face_normal_core_assert.svh
// assertion macros for the fan triangle assembler
// no dependencies; included by the top level only
`ifndef FAN_TRIANGLE_ASSEMBLY_FACE_NORMAL_CORE_ASSERT_SVH
`define FAN_TRIANGLE_ASSEMBLY_FACE_NORMAL_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FTAFN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FTAFN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ftafn_pkg.sv
// shared types, constants and command/status structs of the fan triangle assembler
// no dependencies
`default_nettype none
package ftafn_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_CORNERS = 16;
    localparam int IDX_W           = 11;
    localparam int VAL_W           = 16;
    localparam int IN_DATA_W       = 88;
    localparam int OUT_DATA_W      = 128;
    localparam int MUL_W           = 31;
    localparam int PROD_W          = 62;
    localparam int CRS_W           = 34;
    localparam int MAG_W           = 34;
    localparam int NORM_LO         = 29;
    localparam int NORM_HI         = 30;
    localparam int SMALL_LIMIT     = 42;
    localparam int FRAC_BITS       = 14;
    localparam int Q_W             = 15;
    localparam int ROOT_W          = 31;
    localparam int STEP_W          = 5;
    localparam int SQRT_STEPS      = 31;
    localparam int DIV_STEPS       = 15;

    typedef enum logic [1:0] {
        REQ_POS    = 2'd0,
        REQ_NRM    = 2'd1,
        REQ_TEX    = 2'd2,
        REQ_CORNER = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        MUL_C0A = 4'd0,
        MUL_C0B = 4'd1,
        MUL_C1A = 4'd2,
        MUL_C1B = 4'd3,
        MUL_C2A = 4'd4,
        MUL_C2B = 4'd5,
        MUL_SQ0 = 4'd6,
        MUL_SQ1 = 4'd7,
        MUL_SQ2 = 4'd8
    } t_mul;

    typedef enum logic [1:0] {
        ACC_SET = 2'd0,
        ACC_SUB = 2'd1,
        ACC_SQ  = 2'd2
    } t_acc;

    typedef struct packed {
        logic [IDX_W-1:0] pi;
        logic [IDX_W-1:0] ti;
        logic [IDX_W-1:0] ni;
    } t_corner;

    typedef struct packed {
        logic       in_ready;
        logic       pos_rd;
        logic       vtx_rd;
        logic [1:0] rd_sel;
        logic       pos_cap;
        logic [1:0] cap_sel;
        logic       edge_ld;
        logic       mul_en;
        t_mul       mul_op;
        logic       acc_en;
        t_acc       acc_op;
        logic [1:0] comp;
        logic       mag_ld;
        logic       small_ld;
        logic       norm_step;
        logic       s_clr;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       out_ld;
        logic       tri_end;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic tri_start;
        logic tiny;
        logic norm_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

### design/ftafn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module ftafn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### design/ftafn_ctrl.sv
// sequencer of the fan triangle assembler: steps the datapath through reads,
// cross product, normalization, square root, divisions and vertex output; uses ftafn_pkg
`default_nettype none
module ftafn_ctrl
    import ftafn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_POS   = 11'b000_0000_0010,
        S_CROSS = 11'b000_0000_0100,
        S_MAG   = 11'b000_0000_1000,
        S_CHK   = 11'b000_0001_0000,
        S_NORM  = 11'b000_0010_0000,
        S_SQR   = 11'b000_0100_0000,
        S_SQRT  = 11'b000_1000_0000,
        S_DIV   = 11'b001_0000_0000,
        S_VRD   = 11'b010_0000_0000,
        S_VOUT  = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_k, n_k;
    logic [STEP_W-1:0] w_prev;

    assign w_prev = r_step - STEP_W'(1);

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_k     <= n_k;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step + STEP_W'(1);
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.comp   = r_k;
        o_cmd.rd_sel = r_k;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                n_step = '0;
                if (i_sts.tri_start) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (r_step < STEP_W'(3)) begin
                    o_cmd.pos_rd = 1'b1;
                    o_cmd.rd_sel = r_step[1:0];
                end
                if (r_step >= STEP_W'(1) && r_step <= STEP_W'(3)) begin
                    o_cmd.pos_cap = 1'b1;
                    o_cmd.cap_sel = w_prev[1:0];
                end
                if (r_step == STEP_W'(4)) begin
                    o_cmd.edge_ld = 1'b1;
                    n_state = S_CROSS;
                    n_step  = '0;
                end
            end
            S_CROSS: begin
                if (r_step < STEP_W'(6)) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.mul_op = t_mul'(r_step[3:0]);
                end
                if (r_step >= STEP_W'(1)) begin
                    o_cmd.acc_en = 1'b1;
                    o_cmd.acc_op = w_prev[0] ? ACC_SUB : ACC_SET;
                    o_cmd.comp   = w_prev[2:1];
                end
                if (r_step == STEP_W'(6)) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.mag_ld = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_k = '0;
                if (i_sts.tiny) begin
                    o_cmd.small_ld = 1'b1;
                    n_state = S_VRD;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_step = '0;
                if (i_sts.norm_done) begin
                    o_cmd.s_clr = 1'b1;
                    n_state = S_SQR;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_SQR: begin
                if (r_step < STEP_W'(3)) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.mul_op = t_mul'(4'(MUL_SQ0) + r_step[3:0]);
                end
                if (r_step >= STEP_W'(1)) begin
                    o_cmd.acc_en = 1'b1;
                    o_cmd.acc_op = ACC_SQ;
                end
                if (r_step == STEP_W'(3)) begin
                    n_state = S_SQRT;
                    n_step  = '0;
                end
            end
            S_SQRT: begin
                if (r_step == '0) begin
                    o_cmd.sqrt_init = 1'b1;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
                if (r_step == STEP_W'(SQRT_STEPS)) begin
                    n_state = S_DIV;
                    n_step  = '0;
                    n_k     = '0;
                end
            end
            S_DIV: begin
                if (r_step == '0) begin
                    o_cmd.div_init = 1'b1;
                end else if (r_step <= STEP_W'(DIV_STEPS)) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.div_store = 1'b1;
                    n_step = '0;
                    if (r_k == 2'd2) begin
                        n_state = S_VRD;
                        n_k     = '0;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            S_VRD: begin
                o_cmd.vtx_rd = 1'b1;
                n_state = S_VOUT;
            end
            S_VOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.tri_end = (r_k == 2'd2);
                    if (r_k == 2'd2) begin
                        o_cmd.commit = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 2'd1;
                        n_state = S_VRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/ftafn_dp.sv
// datapath of the fan triangle assembler: attribute stores, corner registers,
// shared multiplier, shift normalizer, square root and divider, output register
// uses ftafn_pkg and ftafn_ram
`default_nettype none
module ftafn_dp
    import ftafn_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_CORNERS = DEF_MAX_CORNERS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_s_tvalid,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic [1:0]            i_s_tuser,
    input  wire logic                  i_s_tlast,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic                       o_m_tlast
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(MAX_CORNERS + 1);
    localparam int XW = (FW > IDX_W) ? FW : IDX_W;

    // index helpers
    function automatic logic f_valid(input logic [IDX_W-1:0] idx, input logic [FW-1:0] fill);
        logic [XW-1:0] wi;
        logic [XW-1:0] wf;
        wi = XW'(idx);
        wf = XW'(fill);
        return (idx != '0) && (wi <= wf);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] idx);
        logic [XW-1:0] w;
        w = XW'(idx) - XW'(1);
        return w[AW-1:0];
    endfunction

    // input unpacking
    t_req                    w_type;
    logic [3*VAL_W-1:0]      w_vals;
    t_corner                 w_cur;
    logic                    w_acc;

    assign w_type = t_req'(i_s_tuser);
    assign w_vals = i_s_tdata[3*VAL_W-1:0];
    assign w_cur  = '{pi: i_s_tdata[58:48], ti: i_s_tdata[69:59], ni: i_s_tdata[80:70]};
    assign w_acc  = i_s_tvalid && i_cmd.in_ready;

    // fills, corner count, output valid
    logic [FW-1:0] r_pfill, r_nfill, r_tfill;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    logic          w_we_p, w_we_n, w_we_t, w_take, w_corner;

    assign w_corner = w_acc && (w_type == REQ_CORNER);
    assign w_we_p   = w_acc && (w_type == REQ_POS) && (r_pfill != FW'(TABLE_DEPTH));
    assign w_we_n   = w_acc && (w_type == REQ_NRM) && (r_nfill != FW'(TABLE_DEPTH));
    assign w_we_t   = w_acc && (w_type == REQ_TEX) && (r_tfill != FW'(TABLE_DEPTH));
    assign w_take   = r_cnt < CW'(MAX_CORNERS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfill     <= '0;
            r_nfill     <= '0;
            r_tfill     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we_p) r_pfill <= r_pfill + FW'(1);
            if (w_we_n) r_nfill <= r_nfill + FW'(1);
            if (w_we_t) r_tfill <= r_tfill + FW'(1);
            if (w_corner) begin
                if (i_s_tlast) begin
                    r_cnt <= '0;
                end else if (w_take) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // corner registers
    t_corner r_first, r_prev, r_cur, w_rc;

    always_ff @(posedge i_clk) begin
        if (w_corner && w_take) begin
            r_cur <= w_cur;
            if (r_cnt == '0) r_first <= w_cur;
            if (r_cnt < CW'(2)) r_prev <= w_cur;
        end
        if (i_cmd.commit) begin
            r_prev <= r_cur;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            2'd0:    w_rc = r_first;
            2'd1:    w_rc = r_prev;
            default: w_rc = r_cur;
        endcase
    end

    // attribute stores
    logic [3*VAL_W-1:0] w_pos_rd, w_nrm_rd;
    logic [2*VAL_W-1:0] w_tex_rd;

    ftafn_ram #(.WIDTH(3*VAL_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_p),
        .i_waddr(r_pfill[AW-1:0]),
        .i_wdata(w_vals),
        .i_re   (i_cmd.pos_rd || i_cmd.vtx_rd),
        .i_raddr(f_addr(w_rc.pi)),
        .o_rdata(w_pos_rd)
    );

    ftafn_ram #(.WIDTH(3*VAL_W), .DEPTH(TABLE_DEPTH)) u_nrm_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_n),
        .i_waddr(r_nfill[AW-1:0]),
        .i_wdata(w_vals),
        .i_re   (i_cmd.vtx_rd),
        .i_raddr(f_addr(w_rc.ni)),
        .o_rdata(w_nrm_rd)
    );

    ftafn_ram #(.WIDTH(2*VAL_W), .DEPTH(TABLE_DEPTH)) u_tex_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_t),
        .i_waddr(r_tfill[AW-1:0]),
        .i_wdata(w_vals[2*VAL_W-1:0]),
        .i_re   (i_cmd.vtx_rd),
        .i_raddr(f_addr(w_rc.ti)),
        .o_rdata(w_tex_rd)
    );

    // validity of the entries being read
    logic r_pv, r_nv, r_tv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_rd || i_cmd.vtx_rd) begin
            r_pv <= f_valid(w_rc.pi, r_pfill);
            r_nv <= f_valid(w_rc.ni, r_nfill);
            r_tv <= f_valid(w_rc.ti, r_tfill);
        end
    end

    // triangle positions and edges
    logic signed [VAL_W-1:0] r_p [3][3];
    logic signed [VAL_W:0]   r_e1 [3];
    logic signed [VAL_W:0]   r_e2 [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_cap) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i_cmd.cap_sel][i] <= r_pv ? w_pos_rd[VAL_W*i +: VAL_W] : '0;
            end
        end
        if (i_cmd.edge_ld) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= (VAL_W+1)'(r_p[1][i]) - (VAL_W+1)'(r_p[0][i]);
                r_e2[i] <= (VAL_W+1)'(r_p[2][i]) - (VAL_W+1)'(r_p[0][i]);
            end
        end
    end

    // shared multiplier with registered product
    logic signed [MUL_W-1:0]  w_ma, w_mb;
    logic signed [PROD_W-1:0] r_prod;
    logic        [MAG_W-1:0]  r_mag [3];
    logic                     r_neg [3];

    always_comb begin
        case (i_cmd.mul_op)
            MUL_C0A: begin w_ma = MUL_W'(r_e1[1]); w_mb = MUL_W'(r_e2[2]); end
            MUL_C0B: begin w_ma = MUL_W'(r_e1[2]); w_mb = MUL_W'(r_e2[1]); end
            MUL_C1A: begin w_ma = MUL_W'(r_e1[2]); w_mb = MUL_W'(r_e2[0]); end
            MUL_C1B: begin w_ma = MUL_W'(r_e1[0]); w_mb = MUL_W'(r_e2[2]); end
            MUL_C2A: begin w_ma = MUL_W'(r_e1[0]); w_mb = MUL_W'(r_e2[1]); end
            MUL_C2B: begin w_ma = MUL_W'(r_e1[1]); w_mb = MUL_W'(r_e2[0]); end
            MUL_SQ0: begin w_ma = {1'b0, r_mag[0][29:0]}; w_mb = {1'b0, r_mag[0][29:0]}; end
            MUL_SQ1: begin w_ma = {1'b0, r_mag[1][29:0]}; w_mb = {1'b0, r_mag[1][29:0]}; end
            MUL_SQ2: begin w_ma = {1'b0, r_mag[2][29:0]}; w_mb = {1'b0, r_mag[2][29:0]}; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
    end

    // cross product accumulation and sum of squares
    logic signed [CRS_W-1:0] r_c [3];
    logic [PROD_W-1:0]       r_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.s_clr) begin
            r_s <= '0;
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.acc_op)
                ACC_SET: r_c[i_cmd.comp] <= r_prod[CRS_W-1:0];
                ACC_SUB: r_c[i_cmd.comp] <= r_c[i_cmd.comp] - r_prod[CRS_W-1:0];
                default: r_s <= r_s + r_prod;
            endcase
        end
    end

    // magnitudes and power-of-two scaling
    logic [MAG_W-1:0] w_or;
    logic             w_lo, w_hi;
    logic [7:0]       w_sq;
    logic             w_tiny;

    assign w_or = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_lo = (w_or[MAG_W-1:NORM_LO] == '0);
    assign w_hi = |w_or[MAG_W-1:NORM_HI];

    always_comb begin
        w_sq   = '0;
        w_tiny = 1'b1;
        for (int i = 0; i < 3; i++) begin
            w_sq = w_sq + 8'(r_mag[i][2:0]) * 8'(r_mag[i][2:0]);
            if (r_mag[i] >= MAG_W'(7)) w_tiny = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_ld) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_c[i][CRS_W-1];
                r_mag[i] <= r_c[i][CRS_W-1] ? MAG_W'(-r_c[i]) : MAG_W'(r_c[i]);
            end
        end else if (i_cmd.norm_step) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= w_lo ? (r_mag[i] << 1) : (r_mag[i] >> 1);
            end
        end
    end

    // digit-by-digit square root, one result bit a cycle
    logic [PROD_W-1:0] r_rad;
    logic [32:0]       r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [34:0]       w_rem2, w_trial;

    assign w_rem2  = {r_rem, r_rad[PROD_W-1 -: 2]};
    assign w_trial = 35'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_s;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= r_rad << 2;
            if (w_rem2 >= w_trial) begin
                r_rem  <= 33'(w_rem2 - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2[32:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // restoring divider, one quotient bit a cycle, and face normal register
    logic [ROOT_W-1:0]       r_drem;
    logic [DIV_STEPS-1:0]    r_dnum;
    logic [Q_W-1:0]          r_q;
    logic [44:0]             w_num;
    logic [ROOT_W:0]         w_dw;
    logic signed [VAL_W-1:0] r_fn [3];
    logic [VAL_W-1:0]        w_q16;

    assign w_num   = {r_mag[i_cmd.comp][29:0], {FRAC_BITS{1'b0}}} + 45'(r_root >> 1);
    assign w_dw    = {r_drem, r_dnum[DIV_STEPS-1]};
    assign w_q16   = VAL_W'(r_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_drem <= ROOT_W'(w_num[44:DIV_STEPS]);
            r_dnum <= w_num[DIV_STEPS-1:0];
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_dnum <= r_dnum << 1;
            if (w_dw >= {1'b0, r_root}) begin
                r_drem <= ROOT_W'(w_dw - {1'b0, r_root});
                r_q    <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_drem <= w_dw[ROOT_W-1:0];
                r_q    <= {r_q[Q_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_store) begin
            r_fn[i_cmd.comp] <= r_neg[i_cmd.comp] ? -w_q16 : w_q16;
        end
        if (i_cmd.small_ld) begin
            for (int i = 0; i < 3; i++) begin
                r_fn[i] <= r_neg[i] ? -VAL_W'((r_mag[i][2:0] + 3'd2) >> 2)
                                    : VAL_W'((r_mag[i][2:0] + 3'd2) >> 2);
            end
        end
    end

    // output register
    logic [OUT_DATA_W-1:0] r_out;
    logic                  r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out[3*VAL_W-1:0] <= r_pv ? w_pos_rd : '0;
            r_out[6*VAL_W-1:3*VAL_W] <= r_nv ? w_nrm_rd : {r_fn[2], r_fn[1], r_fn[0]};
            r_out[8*VAL_W-1:6*VAL_W] <= r_tv ? w_tex_rd : '0;
            r_out_last <= i_cmd.tri_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;

    // status to the sequencer
    assign o_sts.tri_start = w_corner && w_take && (r_cnt >= CW'(2));
    assign o_sts.tiny      = w_tiny && (w_sq <= 8'(SMALL_LIMIT));
    assign o_sts.norm_done = !w_lo && !w_hi;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

endmodule
`default_nettype wire

### design/fan_triangle_assembly_face_normal_core.sv
// loads and corners that close no triangle are taken one per cycle
// a triangle corner drops input ready until its last vertex is loaded for output, stepping
// through position reads, a cross product on one shared multiplier, checks, shift scaling,
// squares, a square root and three divisions, where a tiny face normal skips from the checks
// to the vertices; the three vertices leave through one output register, held by output stalls
// reset: synchronous, active low; clears fills, corner count, sequencer and output valid
`default_nettype none
`include "fan_triangle_assembly_face_normal_core_assert.svh"
module fan_triangle_assembly_face_normal_core
    import ftafn_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_CORNERS = DEF_MAX_CORNERS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // val_x, val_y, val_z, pos_index, tex_index, norm_index, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic [1:0]            s_axis_tuser,
    // last_corner
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tri_end
    output logic                       m_axis_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    ftafn_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    // datapath
    ftafn_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_CORNERS(MAX_CORNERS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tdata (s_axis_tdata),
        .i_s_tuser (s_axis_tuser),
        .i_s_tlast (s_axis_tlast),
        .o_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .o_m_tdata (m_axis_tdata),
        .o_m_tlast (m_axis_tlast)
    );

    assign s_axis_tready = w_cmd.in_ready;

    // checks
    `FTAFN_ASSERT_NOW(a_out_ld_free, i_clk, i_rst_n, w_cmd.out_ld,
        !m_axis_tvalid || m_axis_tready, "vertex loaded over an untaken result")
    `FTAFN_ASSERT_NEXT(a_tri_busy, i_clk, i_rst_n, w_sts.tri_start,
        !s_axis_tready, "input still ready after a triangle corner")
    `FTAFN_ASSERT_NOW(a_div_root, i_clk, i_rst_n, w_cmd.div_init,
        w_sts.norm_done, "division started on unscaled magnitudes")

endmodule
`default_nettype wire

### bench/fan_triangle_assembly_face_normal_core_tb.sv
// testbench for the fan triangle assembler: table loads, fan triangulation and face normals
// depends on ftafn_pkg and fan_triangle_assembly_face_normal_core
`default_nettype none
module fan_triangle_assembly_face_normal_core_tb;
    import ftafn_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int CORNER_CAP  = 16;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct {
        t_req        kind;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [10:0] pi;
        logic [10:0] ti;
        logic [10:0] ni;
        logic        closes;
    } t_corner_req;

    typedef struct {
        logic [127:0] data;
        logic         tri_last;
    } t_vertex;

    // predicts emitted vertices and checks them in order
    class t_face_scoreboard;
        logic [15:0] pos_tab [0:DEPTH-1][0:2];
        logic [15:0] nrm_tab [0:DEPTH-1][0:2];
        logic [15:0] tex_tab [0:DEPTH-1][0:1];
        int          pos_fill;
        int          nrm_fill;
        int          tex_fill;
        t_corner     first_c;
        t_corner     prev_c;
        int          corner_cnt;
        t_vertex     pending [$];
        int          errors;

        function new();
            pos_fill   = 0;
            nrm_fill   = 0;
            tex_fill   = 0;
            first_c    = '0;
            prev_c     = '0;
            corner_cnt = 0;
            errors     = 0;
        endfunction

        function void fetch_pos(int idx, output longint p[3]);
            for (int i = 0; i < 3; i++)
                p[i] = (idx >= 1 && idx <= pos_fill) ? longint'($signed(pos_tab[idx-1][i])) : 0;
        endfunction

        function longint unsigned root64(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void tri_normal(longint p0[3], longint p1[3], longint p2[3],
                                 output logic [15:0] n[3]);
            longint          e1 [3];
            longint          e2 [3];
            longint          c  [3];
            longint unsigned mag [3];
            longint unsigned m;
            longint unsigned s;
            longint unsigned r;
            longint          q;
            bit              ng [3];
            for (int i = 0; i < 3; i++) begin
                e1[i] = p1[i] - p0[i];
                e2[i] = p2[i] - p0[i];
            end
            c[0] = e1[1] * e2[2] - e1[2] * e2[1];
            c[1] = e1[2] * e2[0] - e1[0] * e2[2];
            c[2] = e1[0] * e2[1] - e1[1] * e2[0];
            m = 0;
            for (int i = 0; i < 3; i++) begin
                ng[i]  = c[i] < 0;
                mag[i] = ng[i] ? longint'(-c[i]) : longint'(c[i]);
                if (mag[i] > m) m = mag[i];
            end
            // tiny normal: quarter of the cross product, rounded
            if (m < 65536) begin
                s = 0;
                for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
                if (s <= SMALL_LIMIT) begin
                    for (int i = 0; i < 3; i++) begin
                        q    = longint'((mag[i] + 2) >> 2);
                        n[i] = ng[i] ? 16'(-q) : 16'(q);
                    end
                    return;
                end
            end
            // scale the largest magnitude into [2^29, 2^30)
            while (m < (64'd1 << 29)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            while (m >= (64'd1 << 30)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            s = 0;
            for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
            r = root64(s);
            for (int i = 0; i < 3; i++) begin
                q    = longint'((mag[i] * 16384 + r / 2) / r);
                n[i] = ng[i] ? 16'(-q) : 16'(q);
            end
        endfunction

        function t_vertex make_vertex(t_corner cr, logic [15:0] fn[3], bit tend);
            t_vertex v;
            longint  p [3];
            int      ni;
            int      ti;
            fetch_pos(cr.pi, p);
            ni = cr.ni;
            ti = cr.ti;
            for (int i = 0; i < 3; i++) begin
                v.data[16*i +: 16]     = 16'(p[i]);
                v.data[48 + 16*i +: 16] = (ni >= 1 && ni <= nrm_fill) ? nrm_tab[ni-1][i] : fn[i];
            end
            for (int i = 0; i < 2; i++)
                v.data[96 + 16*i +: 16] = (ti >= 1 && ti <= tex_fill) ? tex_tab[ti-1][i] : 16'd0;
            v.tri_last = tend;
            return v;
        endfunction

        function void note_input(t_corner_req it);
            t_corner     cur;
            longint      p0 [3];
            longint      p1 [3];
            longint      p2 [3];
            logic [15:0] fn [3];
            case (it.kind)
                REQ_POS: begin
                    if (pos_fill < DEPTH) begin
                        pos_tab[pos_fill] = '{it.vx, it.vy, it.vz};
                        pos_fill++;
                    end
                end
                REQ_NRM: begin
                    if (nrm_fill < DEPTH) begin
                        nrm_tab[nrm_fill] = '{it.vx, it.vy, it.vz};
                        nrm_fill++;
                    end
                end
                REQ_TEX: begin
                    if (tex_fill < DEPTH) begin
                        tex_tab[tex_fill] = '{it.vx, it.vy};
                        tex_fill++;
                    end
                end
                default: begin
                    cur.pi = it.pi;
                    cur.ti = it.ti;
                    cur.ni = it.ni;
                    if (corner_cnt < CORNER_CAP) begin
                        if (corner_cnt == 0) begin
                            first_c = cur;
                        end else if (corner_cnt >= 2) begin
                            fetch_pos(first_c.pi, p0);
                            fetch_pos(prev_c.pi, p1);
                            fetch_pos(cur.pi, p2);
                            tri_normal(p0, p1, p2, fn);
                            pending.push_back(make_vertex(first_c, fn, 1'b0));
                            pending.push_back(make_vertex(prev_c, fn, 1'b0));
                            pending.push_back(make_vertex(cur, fn, 1'b1));
                        end
                        prev_c = cur;
                        corner_cnt++;
                    end
                    if (it.closes) corner_cnt = 0;
                end
            endcase
        endfunction

        function void check_result(logic [127:0] d, logic l);
            t_vertex exp_v;
            string   names [8];
            names = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y", "nrm_z", "tex_u", "tex_v"};
            if (pending.size() == 0) begin
                $error("vertex with no expected vertex waiting");
                errors++;
                return;
            end
            exp_v = pending.pop_front();
            for (int k = 0; k < 8; k++) begin
                if (d[16*k +: 16] !== exp_v.data[16*k +: 16]) begin
                    $error("%s expected %0d actual %0d", names[k],
                           $signed(exp_v.data[16*k +: 16]), $signed(d[16*k +: 16]));
                    errors++;
                end
            end
            if (l !== exp_v.tri_last) begin
                $error("tri_end expected %0d actual %0d", exp_v.tri_last, l);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    t_face_scoreboard vertex_board;
    int               cycle_cnt;
    int               burst_left;
    int               sent_cnt;
    int               stall_mode;

    fan_triangle_assembly_face_normal_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern, in one of four randomly chosen modes
    always @(negedge i_clk) begin
        if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready = 1'b1;
            1:       m_axis_tready = $urandom_range(0, 1);
            2:       m_axis_tready = (cycle_cnt % 4 == 0);
            default: m_axis_tready = ($urandom_range(0, 9) != 0);
        endcase
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            vertex_board.check_result(m_axis_tdata, m_axis_tlast);
    end

    // one input transaction, with bursts and gaps
    task automatic send_item(t_corner_req it);
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.kind;
        s_axis_tlast  = it.closes;
        s_axis_tdata  = {7'd0, it.ni, it.ti, it.pi, it.vz, it.vy, it.vx};
        do @(posedge i_clk); while (!s_axis_tready);
        vertex_board.note_input(it);
        sent_cnt++;
    endtask

    task automatic send_load(t_req kind, int x, int y, int z);
        t_corner_req it;
        it.kind   = kind;
        it.vx     = 16'(x);
        it.vy     = 16'(y);
        it.vz     = 16'(z);
        it.pi     = 11'($urandom);
        it.ti     = 11'($urandom);
        it.ni     = 11'($urandom);
        it.closes = $urandom_range(0, 1);
        send_item(it);
    endtask

    task automatic send_corner(int pi, int ti, int ni, bit closes);
        t_corner_req it;
        it.kind   = REQ_CORNER;
        it.vx     = 16'($urandom);
        it.vy     = 16'($urandom);
        it.vz     = 16'($urandom);
        it.pi     = 11'(pi);
        it.ti     = 11'(ti);
        it.ni     = 11'(ni);
        it.closes = closes;
        send_item(it);
    endtask

    // index mostly inside the table or one past its end, sometimes absent or anything in 11 bits
    function automatic int pick_index(int fill);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1 || fill == 0) return $urandom_range(0, 2047);
        return $urandom_range(1, fill + 1);
    endfunction

    task automatic send_polygon();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(3, 6);
        for (int k = 0; k < n; k++)
            send_corner(pick_index(vertex_board.pos_fill), pick_index(vertex_board.tex_fill),
                        ($urandom_range(0, 1) ? 0 : pick_index(vertex_board.nrm_fill)),
                        k == n - 1);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_POS;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cycle_cnt     = 0;
        burst_left    = 0;
        sent_cnt      = 0;
        stall_mode    = 0;
        vertex_board  = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes of loads
        send_load(REQ_POS, 0, 0, 0);
        send_load(REQ_POS, 256, 0, 0);
        send_load(REQ_POS, 0, 256, 0);
        send_load(REQ_POS, 1, 0, 0);
        send_load(REQ_POS, 0, 1, 0);
        send_load(REQ_POS, 32767, -32768, 32767);
        send_load(REQ_POS, -32768, 32767, -32768);
        send_load(REQ_NRM, 16384, 0, 0);
        send_load(REQ_NRM, -32768, 32767, -1);
        send_load(REQ_TEX, 4096, -4096, 0);
        send_load(REQ_TEX, 32767, -32768, 0);
        // plain face normal, tiny face normal, stored normal and texcoord
        send_corner(1, 1, 0, 0); send_corner(2, 0, 0, 0); send_corner(3, 2, 0, 1);
        send_corner(1, 0, 0, 0); send_corner(4, 0, 0, 0); send_corner(5, 0, 2, 1);
        // extreme positions, invalid indices, collinear and short polygons
        send_corner(6, 3, 3, 0); send_corner(7, 2047, 1, 0); send_corner(0, 0, 0, 0);
        send_corner(2047, 1, 2047, 1);
        send_corner(1, 0, 0, 0); send_corner(2, 0, 0, 0); send_corner(2, 0, 0, 1);
        send_corner(8, 0, 0, 0); send_corner(1, 0, 0, 1);

        // random: mostly polygons over a growing set of tables
        while (sent_cnt < 300) begin
            if ($urandom_range(0, 9) < 3)
                send_load(t_req'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
            else
                send_polygon();
        end

        // a few more polygons, then indices at the top of the table range
        repeat (4) send_polygon();
        send_corner(1024, 1024, 1024, 0); send_corner(1023, 1, 0, 0);
        send_corner(1, 1024, 0, 1);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (vertex_board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (vertex_board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
+incdir+design
design/ftafn_pkg.sv
design/ftafn_ram.sv
design/ftafn_ctrl.sv
design/ftafn_dp.sv
design/fan_triangle_assembly_face_normal_core.sv
bench/fan_triangle_assembly_face_normal_core_tb.sv
